// ===== rtl/core/edpq_pkg.sv =====
package edpq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;

   // csr map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_GLITCH_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_STEPS_PER_DETENT = 2'd1;
   localparam logic [1:0] REG_NARROW_COUNTER   = 2'd2;

   // field widths
   localparam int COUNT_W   = 32;
   localparam int THRESH_W  = 7;
   localparam int STEP_W    = 5;
   localparam int RESIDUE_W = 8;
   localparam int SUM_W     = 9;
   localparam int SUM_MAG_W = SUM_W - 1;
   localparam int DETENT_W  = 8;
   localparam int PHASE_W   = 2;
   localparam int DEPTH_W   = 6;
   localparam int NARROW_W  = 16;

   localparam logic [THRESH_W-1:0] GLITCH_THRESHOLD_RESET = 7'd20;
   localparam logic [STEP_W-1:0]   STEPS_PER_DETENT_RESET = 5'd4;

   // five phases per detent, quotient up to 157 -> 785 pushes at most
   localparam int PHASES_PER_DETENT = 5;
   localparam int SEQ_IDX_W = $clog2(PHASES_PER_DETENT);
   localparam int PUSH_W    = 10;

   localparam logic [PHASE_W-1:0] SEQ_POS [PHASES_PER_DETENT] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0};
   localparam logic [PHASE_W-1:0] SEQ_NEG [PHASES_PER_DETENT] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd0};

   localparam int DIV_CNT_W = $clog2(SUM_MAG_W);

   typedef struct packed {
      logic                 done;
      logic [SUM_MAG_W-1:0] quotient;
      logic [STEP_W-1:0]    remainder;
   } div_status_type;

endpackage

// ===== rtl/core/edpq_divider.sv =====
module edpq_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [edpq_pkg::SUM_MAG_W-1:0] dividend,
   input  logic [edpq_pkg::STEP_W-1:0]    divisor,
   output edpq_pkg::div_status_type       status
);

   logic                           run_ff;
   logic                           done_ff;
   logic [edpq_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [edpq_pkg::SUM_MAG_W-1:0] quo_ff;
   logic [edpq_pkg::STEP_W-1:0]    rem_ff;
   logic [edpq_pkg::STEP_W-1:0]    div_ff;
   logic [edpq_pkg::STEP_W:0]      trial;
   logic [edpq_pkg::STEP_W:0]      trial_sub;
   logic                           fits;

   // one extra bit, the remainder can use the divisor's top bit
   assign trial     = {rem_ff, quo_ff[edpq_pkg::SUM_MAG_W-1]};
   assign fits      = (trial >= {1'b0, div_ff});
   assign trial_sub = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == edpq_pkg::DIV_CNT_W'(edpq_pkg::SUM_MAG_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[edpq_pkg::SUM_MAG_W-2:0], fits};
         rem_ff <= fits ? trial_sub[edpq_pkg::STEP_W-1:0] : trial[edpq_pkg::STEP_W-1:0];
      end
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

   property p_done_after_run;
      @(posedge clock) disable iff (reset)
         done_ff |-> !run_ff;
   endproperty
   a_done_after_run: assert property (p_done_after_run)
      else $error("divider done while still running");

   property p_rem_below_divisor;
      @(posedge clock) disable iff (reset)
         done_ff |-> (rem_ff < div_ff);
   endproperty
   a_rem_below_divisor: assert property (p_rem_below_divisor)
      else $error("divider remainder not below divisor");

   property p_start_runs;
      @(posedge clock) disable iff (reset)
         start |=> run_ff;
   endproperty
   a_start_runs: assert property (p_start_runs)
      else $error("divider did not start");

endmodule

// ===== rtl/core/encoder_detent_phase_queue.sv =====
// Encoder detent counter with a phase queue. Each request beat is either a
// counter sample (kind 0) or a pop (kind 1), and each gives exactly one
// response beat. A sample forms the signed count change since the previous
// sample (wrapped at 16 bits when narrow_counter is set), rejects it as a
// glitch when its size exceeds glitch_threshold, and otherwise adds it to a
// residue from which whole detents are taken; each detent writes the phases
// 0,1,3,2,0 (positive) or 0,2,3,1,0 (negative) into the queue until it is
// full. A pop returns the oldest phase. A pop passes through ST_POP, a
// glitch through ST_CALC and ST_CHECK, and any other sample, the first after
// reset included, through ST_CALC, ST_CHECK, ST_NORM, ST_DIVIDE (the
// bit-serial divider, 8 steps), ST_PLAN and ST_PUSH, which writes the phases
// through the single write port of the phase memory; each ends in ST_RESULT.
// One request is in flight at a time; the output register lets the next request enter while a response waits.
// The phase memory is not cleared after reset; only written entries are read.
module encoder_detent_phase_queue #(
   parameter int QUEUE_DEPTH = edpq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [edpq_pkg::COUNT_W-1:0]           req_counter_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [edpq_pkg::COUNT_W-1:0]    rsp_count_change,
   output logic signed [edpq_pkg::DETENT_W-1:0]   rsp_detent_step,
   output logic                                   rsp_glitch_rejected,
   output logic                                   rsp_pop_valid,
   output logic [edpq_pkg::PHASE_W-1:0]           rsp_phase_ab,
   output logic [edpq_pkg::PHASE_W-1:0]           rsp_last_pushed_ab,
   output logic [edpq_pkg::DEPTH_W-1:0]           rsp_queue_depth,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [edpq_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [edpq_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [edpq_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W    = (CNT_W > edpq_pkg::PUSH_W) ? CNT_W : edpq_pkg::PUSH_W;
   localparam int FILL_X_W = CNT_W + edpq_pkg::DEPTH_W;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CALC   = 9'b000000010,
      ST_CHECK  = 9'b000000100,
      ST_NORM   = 9'b000001000,
      ST_DIVIDE = 9'b000010000,
      ST_PLAN   = 9'b000100000,
      ST_PUSH   = 9'b001000000,
      ST_POP    = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [edpq_pkg::THRESH_W-1:0] thr_ff, thr_in;
   logic [edpq_pkg::STEP_W-1:0]   steps_ff, steps_in;
   logic                          narrow_ff, narrow_in;

   // block state
   logic [edpq_pkg::COUNT_W-1:0]   prev_ff, prev_in;
   logic                           started_ff, started_in;
   logic [edpq_pkg::RESIDUE_W-1:0] residue_ff, residue_in;
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic [PTR_W-1:0]               rp_ff, rp_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [edpq_pkg::PHASE_W-1:0]   last_phase_ff, last_phase_in;

   // per-item working registers
   logic [edpq_pkg::COUNT_W-1:0]   cur_ff, cur_in;
   logic [edpq_pkg::COUNT_W-1:0]   delta_ff, delta_in;
   logic                           glitch_ff, glitch_in;
   logic [edpq_pkg::SUM_W-1:0]     detents_ff, detents_in;
   logic                           popv_ff, popv_in;
   logic [edpq_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [edpq_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic                           sum_neg_ff, sum_neg_in;
   logic [CNT_W-1:0]               push_left_ff, push_left_in;
   logic [edpq_pkg::SEQ_IDX_W-1:0] seq_idx_ff, seq_idx_in;

   // response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [edpq_pkg::COUNT_W-1:0]         rsp_delta_ff, rsp_delta_in;
   logic [edpq_pkg::DETENT_W-1:0]        rsp_detent_ff, rsp_detent_in;
   logic                                 rsp_glitch_ff, rsp_glitch_in;
   logic                                 rsp_popv_ff, rsp_popv_in;
   logic [edpq_pkg::PHASE_W-1:0]         rsp_phase_ff, rsp_phase_in;
   logic [edpq_pkg::PHASE_W-1:0]         rsp_last_ff, rsp_last_in;
   logic [edpq_pkg::DEPTH_W-1:0]         rsp_depth_ff, rsp_depth_in;

   // phase memory
   logic [edpq_pkg::PHASE_W-1:0] phase_mem [QUEUE_DEPTH];
   logic [edpq_pkg::PHASE_W-1:0] rd_data_ff;
   logic                         mem_we;
   logic                         mem_re;
   logic [edpq_pkg::PHASE_W-1:0] mem_wdata;

   // divider
   edpq_pkg::div_status_type       div_status;
   logic                           div_start;
   logic [edpq_pkg::SUM_W-1:0]     sum_abs;
   logic [edpq_pkg::STEP_W-1:0]    div_divisor;

   // combinational helpers
   logic                           req_accept;
   logic                           csr_write;
   logic [edpq_pkg::COUNT_W-1:0]   diff;
   logic [edpq_pkg::COUNT_W-1:0]   mag;
   logic [edpq_pkg::SUM_W-1:0]     quo_ext;
   logic [edpq_pkg::RESIDUE_W-1:0] rem_ext;
   logic [CMP_W-1:0]               push_want;
   logic [CMP_W-1:0]               push_room;
   logic [FILL_X_W-1:0]            fill_ext;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign diff    = cur_ff - prev_ff;
   assign mag     = delta_ff[edpq_pkg::COUNT_W-1] ? (~delta_ff + 1'b1) : delta_ff;
   assign sum_abs = sum_ff[edpq_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign div_divisor = (steps_ff == '0) ? edpq_pkg::STEP_W'(1) : steps_ff;

   assign quo_ext   = edpq_pkg::SUM_W'(div_status.quotient);
   assign rem_ext   = edpq_pkg::RESIDUE_W'(div_status.remainder);
   assign push_want = CMP_W'({quo_ext, 2'b00}) + CMP_W'(quo_ext);
   assign push_room = CMP_W'(QUEUE_DEPTH) - CMP_W'(fill_ff);
   assign fill_ext  = FILL_X_W'(fill_ff);

   assign mem_wdata = sum_neg_ff ? edpq_pkg::SEQ_NEG[seq_idx_ff]
                                 : edpq_pkg::SEQ_POS[seq_idx_ff];

   edpq_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_abs[edpq_pkg::SUM_MAG_W-1:0]),
      .divisor  (div_divisor),
      .status   (div_status)
   );

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      steps_in      = steps_ff;
      narrow_in     = narrow_ff;
      prev_in       = prev_ff;
      started_in    = started_ff;
      residue_in    = residue_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      fill_in       = fill_ff;
      last_phase_in = last_phase_ff;
      cur_in        = cur_ff;
      delta_in      = delta_ff;
      glitch_in     = glitch_ff;
      detents_in    = detents_ff;
      popv_in       = popv_ff;
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      sum_neg_in    = sum_neg_ff;
      push_left_in  = push_left_ff;
      seq_idx_in    = seq_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_delta_in  = rsp_delta_ff;
      rsp_detent_in = rsp_detent_ff;
      rsp_glitch_in = rsp_glitch_ff;
      rsp_popv_in   = rsp_popv_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_depth_in  = rsp_depth_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      div_start     = 1'b0;

      if (csr_write) begin
         case (csr_paddr[3:2])
            edpq_pkg::REG_GLITCH_THRESHOLD: thr_in    = csr_pwdata[edpq_pkg::THRESH_W-1:0];
            edpq_pkg::REG_STEPS_PER_DETENT: steps_in  = csr_pwdata[edpq_pkg::STEP_W-1:0];
            edpq_pkg::REG_NARROW_COUNTER:   narrow_in = csr_pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cur_in     = req_counter_value;
               delta_in   = '0;
               glitch_in  = 1'b0;
               detents_in = '0;
               popv_in    = 1'b0;
               phase_in   = '0;
               mem_re     = req_kind;
               state_in   = req_kind ? ST_POP : ST_CALC;
            end
         end
         ST_CALC: begin
            if (!started_ff) begin
               started_in = 1'b1;
            end else if (narrow_ff) begin
               delta_in = {{(edpq_pkg::COUNT_W-edpq_pkg::NARROW_W){diff[edpq_pkg::NARROW_W-1]}},
                           diff[edpq_pkg::NARROW_W-1:0]};
            end else begin
               delta_in = diff;
            end
            prev_in  = cur_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (mag > edpq_pkg::COUNT_W'(thr_ff)) begin
               glitch_in = 1'b1;
               state_in  = ST_RESULT;
            end else begin
               // an accepted delta is within 7 bits of magnitude
               sum_in   = {residue_ff[edpq_pkg::RESIDUE_W-1], residue_ff}
                          + delta_ff[edpq_pkg::SUM_W-1:0];
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            sum_neg_in = sum_ff[edpq_pkg::SUM_W-1];
            div_start  = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            // truncation toward zero: quotient and remainder take the sign of the sum
            detents_in   = sum_neg_ff ? (~quo_ext + 1'b1) : quo_ext;
            residue_in   = sum_neg_ff ? (~rem_ext + 1'b1) : rem_ext;
            push_left_in = (push_want < push_room) ? push_want[CNT_W-1:0]
                                                   : push_room[CNT_W-1:0];
            seq_idx_in   = '0;
            state_in     = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_left_ff != '0) begin
               mem_we        = 1'b1;
               last_phase_in = mem_wdata;
               wp_in         = (wp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               fill_in       = fill_ff + 1'b1;
               push_left_in  = push_left_ff - 1'b1;
               seq_idx_in    = (seq_idx_ff == edpq_pkg::SEQ_IDX_W'(edpq_pkg::PHASES_PER_DETENT - 1))
                               ? '0 : seq_idx_ff + 1'b1;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_POP: begin
            if (fill_ff != '0) begin
               popv_in  = 1'b1;
               phase_in = rd_data_ff;
               rp_in    = (rp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
               fill_in  = fill_ff - 1'b1;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_delta_in  = delta_ff;
               rsp_detent_in = detents_ff[edpq_pkg::DETENT_W-1:0];
               rsp_glitch_in = glitch_ff;
               rsp_popv_in   = popv_ff;
               rsp_phase_in  = phase_ff;
               rsp_last_in   = last_phase_ff;
               rsp_depth_in  = fill_ext[edpq_pkg::DEPTH_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= edpq_pkg::GLITCH_THRESHOLD_RESET;
         steps_ff      <= edpq_pkg::STEPS_PER_DETENT_RESET;
         narrow_ff     <= 1'b0;
         prev_ff       <= '0;
         started_ff    <= 1'b0;
         residue_ff    <= '0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         fill_ff       <= '0;
         last_phase_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         steps_ff      <= steps_in;
         narrow_ff     <= narrow_in;
         prev_ff       <= prev_in;
         started_ff    <= started_in;
         residue_ff    <= residue_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         fill_ff       <= fill_in;
         last_phase_ff <= last_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      delta_ff      <= delta_in;
      glitch_ff     <= glitch_in;
      detents_ff    <= detents_in;
      popv_ff       <= popv_in;
      phase_ff      <= phase_in;
      sum_ff        <= sum_in;
      sum_neg_ff    <= sum_neg_in;
      push_left_ff  <= push_left_in;
      seq_idx_ff    <= seq_idx_in;
      rsp_delta_ff  <= rsp_delta_in;
      rsp_detent_ff <= rsp_detent_in;
      rsp_glitch_ff <= rsp_glitch_in;
      rsp_popv_ff   <= rsp_popv_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         phase_mem[wp_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= phase_mem[rp_ff];
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         edpq_pkg::REG_GLITCH_THRESHOLD: csr_prdata = edpq_pkg::CSR_DATA_W'(thr_ff);
         edpq_pkg::REG_STEPS_PER_DETENT: csr_prdata = edpq_pkg::CSR_DATA_W'(steps_ff);
         edpq_pkg::REG_NARROW_COUNTER:   csr_prdata = edpq_pkg::CSR_DATA_W'(narrow_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_count_change    = rsp_delta_ff;
   assign rsp_detent_step     = rsp_detent_ff;
   assign rsp_glitch_rejected = rsp_glitch_ff;
   assign rsp_pop_valid       = rsp_popv_ff;
   assign rsp_phase_ab        = rsp_phase_ff;
   assign rsp_last_pushed_ab  = rsp_last_ff;
   assign rsp_queue_depth     = rsp_depth_ff;

   property p_fill_bounded;
      @(posedge clock) disable iff (reset)
         fill_ff <= CNT_W'(QUEUE_DEPTH);
   endproperty
   a_fill_bounded: assert property (p_fill_bounded)
      else $error("phase queue fill beyond depth");

   property p_write_needs_room;
      @(posedge clock) disable iff (reset)
         mem_we |-> (state_ff == ST_PUSH) && (fill_ff < CNT_W'(QUEUE_DEPTH));
   endproperty
   a_write_needs_room: assert property (p_write_needs_room)
      else $error("phase write into a full queue");

   property p_write_counts;
      @(posedge clock) disable iff (reset)
         mem_we |=> fill_ff == $past(fill_ff) + CNT_W'(1);
   endproperty
   a_write_counts: assert property (p_write_counts)
      else $error("phase write not counted");

   property p_accept_leaves_idle;
      @(posedge clock) disable iff (reset)
         req_accept |=> (state_ff != ST_IDLE);
   endproperty
   a_accept_leaves_idle: assert property (p_accept_leaves_idle)
      else $error("accepted beat not taken up");

   property p_glitch_no_detent;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_glitch_ff) |-> (rsp_detent_ff == '0) && !rsp_popv_ff;
   endproperty
   a_glitch_no_detent: assert property (p_glitch_no_detent)
      else $error("glitch response carries detents");

endmodule

// ===== verif/encoder_detent_phase_queue_tb.sv =====
`timescale 1ns / 1ps

module encoder_detent_phase_queue_tb;

   localparam int PHASE_SLOTS = edpq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int PHASE_ITEMS = 75;
   localparam int DRAIN_CYCLES = 60;

   typedef enum logic {KIND_SAMPLE = 1'b0, KIND_POP = 1'b1} item_kind_type;
   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   typedef struct packed {
      logic signed [31:0] count_change;
      logic signed [7:0]  detent_step;
      logic               glitch_rejected;
      logic               pop_valid;
      logic [1:0]         phase_ab;
      logic [1:0]         last_pushed_ab;
      logic [5:0]         queue_depth;
   } result_type;

   typedef struct {
      row_op_type    op;
      item_kind_type kind;
      logic [31:0]   value;
      bit            typed;
      result_type    want;
      int            thr;
      int            steps;
      int            narrow;
   } directed_row_type;

   localparam result_type ZERO_RESULT = '0;
   localparam logic [1:0] CW_PHASES [5] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0};
   localparam logic [1:0] CCW_PHASES [5] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_kind = 1'b0;
   logic [31:0] req_counter_value = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [edpq_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [edpq_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;

   wire         req_stall;
   wire         rsp_valid;
   wire signed [31:0] rsp_count_change;
   wire signed [7:0]  rsp_detent_step;
   wire         rsp_glitch_rejected;
   wire         rsp_pop_valid;
   wire [1:0]   rsp_phase_ab;
   wire [1:0]   rsp_last_pushed_ab;
   wire [5:0]   rsp_queue_depth;
   wire [edpq_pkg::CSR_DATA_W-1:0] csr_prdata;
   wire         csr_pready;

   // predictor state and register copies
   logic [6:0]  cfg_threshold = 7'd20;
   logic [4:0]  cfg_steps = 5'd4;
   logic        cfg_narrow = 1'b0;
   logic [31:0] held_count = '0;
   bit          counting = 1'b0;
   int          residue = 0;
   logic [1:0]  last_phase = 2'd0;
   logic [1:0]  stored_phases[$];

   result_type  pending_results[$];
   int          mismatch_count = 0;
   bit          rush = 1'b0;

   directed_row_type directed_rows[$] = '{
      '{ROW_ITEM, KIND_POP,    32'h0000_0000, 1'b1, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0010, 1'b1, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0025, 1'b1,
        '{32'sd21, 8'sd0, 1'b1, 1'b0, 2'd0, 2'd0, 6'd0}, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h8000_0025, 1'b1,
        '{32'sh8000_0000, 8'sd0, 1'b1, 1'b0, 2'd0, 2'd0, 6'd0}, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'hFFFF_FFFF, 1'b1,
        '{32'sh7FFF_FFDA, 8'sd0, 1'b1, 1'b0, 2'd0, 2'd0, 6'd0}, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0013, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0027, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_002A, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_POP,    32'hFFFF_FFFF, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_POP,    32'h0000_0000, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_POP,    32'h5A5A_A5A5, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0024, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0022, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h0000_0000, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_CSR,  KIND_SAMPLE, 32'h0000_0000, 1'b0, ZERO_RESULT, 100, 0, 1},
      '{ROW_ITEM, KIND_SAMPLE, 32'h1234_0009, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_POP,    32'h0000_0000, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_POP,    32'h0000_0000, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'h1233_FFF0, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'hABCD_0050, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_CSR,  KIND_SAMPLE, 32'h0000_0000, 1'b0, ZERO_RESULT, 0, 16, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'hABCD_0050, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_SAMPLE, 32'hABCD_0051, 1'b0, ZERO_RESULT, 0, 0, 0},
      '{ROW_ITEM, KIND_POP,    32'h0000_0000, 1'b0, ZERO_RESULT, 0, 0, 0}
   };

   encoder_detent_phase_queue uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_counter_value   (req_counter_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_count_change    (rsp_count_change),
      .rsp_detent_step     (rsp_detent_step),
      .rsp_glitch_rejected (rsp_glitch_rejected),
      .rsp_pop_valid       (rsp_pop_valid),
      .rsp_phase_ab        (rsp_phase_ab),
      .rsp_last_pushed_ab  (rsp_last_pushed_ab),
      .rsp_queue_depth     (rsp_queue_depth),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type predict_detents(item_kind_type kind, logic [31:0] value);
      result_type  r;
      logic [31:0] change;
      logic [31:0] magnitude;
      int          divisor;
      int          sum;
      int          whole;
      int          pushes;
      r = '0;
      change = '0;
      if (kind == KIND_SAMPLE) begin
         if (!counting) begin
            held_count = value;
            counting = 1'b1;
         end else begin
            change = value - held_count;
            if (cfg_narrow) change = {{16{change[15]}}, change[15:0]};
            held_count = value;
         end
         magnitude = change[31] ? -change : change;
         r.count_change = change;
         if (magnitude > cfg_threshold) begin
            r.glitch_rejected = 1'b1;
         end else begin
            divisor = (cfg_steps == 0) ? 1 : int'(cfg_steps);
            sum = residue + $signed(change);
            whole = sum / divisor;
            residue = sum - whole * divisor;
            r.detent_step = whole[7:0];
            pushes = 5 * ((whole < 0) ? -whole : whole);
            // phases past the first full slot are dropped
            for (int k = 0; k < pushes && stored_phases.size() < PHASE_SLOTS; k++) begin
               last_phase = (whole > 0) ? CW_PHASES[k % 5] : CCW_PHASES[k % 5];
               stored_phases.push_back(last_phase);
            end
         end
      end else if (stored_phases.size() != 0) begin
         r.pop_valid = 1'b1;
         r.phase_ab = stored_phases.pop_front();
      end
      r.last_pushed_ab = last_phase;
      r.queue_depth = 6'(stored_phases.size());
      return r;
   endfunction

   function automatic int draw_wait();
      return rush ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic report_mismatch(input string text);
      $display("mismatch at %0t ns: %s", $time, text);
      mismatch_count++;
   endtask

   task automatic send_item(input item_kind_type kind, input logic [31:0] value,
                            input bit typed, input result_type want);
      int         gap;
      result_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_counter_value <= value;
      do @(posedge clock); while (req_stall);
      predicted = predict_detents(kind, value);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_settings(input int thr, input int steps, input int narrow);
      settle();
      write_csr(edpq_pkg::REG_GLITCH_THRESHOLD, thr);
      cfg_threshold = thr[6:0];
      write_csr(edpq_pkg::REG_STEPS_PER_DETENT, steps);
      cfg_steps = steps[4:0];
      write_csr(edpq_pkg::REG_NARROW_COUNTER, narrow);
      cfg_narrow = narrow[0];
   endtask

   initial begin : response_side
      result_type seen;
      result_type want;
      int         hold;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         seen = '{rsp_count_change, rsp_detent_step, rsp_glitch_rejected, rsp_pop_valid,
                  rsp_phase_ab, rsp_last_pushed_ab, rsp_queue_depth};
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with nothing outstanding");
         end else begin
            want = pending_results.pop_front();
            if (seen.count_change !== want.count_change)
               report_mismatch($sformatf("count_change %0d, want %0d",
                                         seen.count_change, want.count_change));
            if (seen.detent_step !== want.detent_step)
               report_mismatch($sformatf("detent_step %0d, want %0d",
                                         seen.detent_step, want.detent_step));
            if (seen.glitch_rejected !== want.glitch_rejected)
               report_mismatch($sformatf("glitch_rejected %b, want %b",
                                         seen.glitch_rejected, want.glitch_rejected));
            if (seen.pop_valid !== want.pop_valid)
               report_mismatch($sformatf("pop_valid %b, want %b",
                                         seen.pop_valid, want.pop_valid));
            if (seen.phase_ab !== want.phase_ab)
               report_mismatch($sformatf("phase_ab %0d, want %0d",
                                         seen.phase_ab, want.phase_ab));
            if (seen.last_pushed_ab !== want.last_pushed_ab)
               report_mismatch($sformatf("last_pushed_ab %0d, want %0d",
                                         seen.last_pushed_ab, want.last_pushed_ab));
            if (seen.queue_depth !== want.queue_depth)
               report_mismatch($sformatf("queue_depth %0d, want %0d",
                                         seen.queue_depth, want.queue_depth));
         end
      end
   end

   initial begin : stimulus
      int          phase_thr [5] = '{20, 100, 100, 0, 7};
      int          phase_steps [5] = '{4, 1, 16, 0, 3};
      int          phase_narrow [5] = '{0, 0, 1, 0, 1};
      int          thr;
      int          steps;
      int          narrow;
      int          roll;
      int          pop_odds;
      int          span;
      logic [31:0] value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_CSR)
            apply_settings(directed_rows[i].thr, directed_rows[i].steps,
                           directed_rows[i].narrow);
         else
            send_item(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < 7; phase++) begin
         if (phase < 5) begin
            thr = phase_thr[phase];
            steps = phase_steps[phase];
            narrow = phase_narrow[phase];
         end else begin
            thr = $urandom_range(0, 100);
            steps = $urandom_range(0, 16);
            narrow = $urandom_range(0, 1);
         end
         apply_settings(thr, steps, narrow);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            rush = (n % 40) >= 32;
            roll = $urandom_range(0, 99);
            // steer the queue between empty and full
            pop_odds = (stored_phases.size() >= 24) ? 70 :
                       (stored_phases.size() < 6) ? 15 : 45;
            if (roll < pop_odds) begin
               send_item(KIND_POP, $urandom, 1'b0, ZERO_RESULT);
            end else if ($urandom_range(0, 9) == 0) begin
               send_item(KIND_SAMPLE, $urandom, 1'b0, ZERO_RESULT);
            end else begin
               span = thr + 3;
               value = held_count + ($urandom_range(0, 2 * span) - span);
               // upper half is don't-care for the delta in narrow mode
               if (cfg_narrow && $urandom_range(0, 1)) value[31:16] = 16'($urandom);
               send_item(KIND_SAMPLE, value, 1'b0, ZERO_RESULT);
            end
         end
         rush = 1'b0;
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/edpq_pkg.sv
rtl/core/edpq_divider.sv
rtl/core/encoder_detent_phase_queue.sv
verif/encoder_detent_phase_queue_tb.sv
